@@ hw/rtl/positional_array_list_engine_macros.svh @@
// Assertion helpers shared by the list engine RTL.
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PAL_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list engine assertion failed");

// Next-cycle implication, disabled in reset.
`define PAL_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list engine assertion failed");

`endif

@@ hw/rtl/pal_pkg.sv @@
package pal_pkg;

   localparam int CAPACITY_DEF = 64;

   // Field widths
   localparam int OP_W      = 3;
   localparam int POS_W     = 7;
   localparam int DATA_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int FIDX_W    = 6;
   localparam int CNT_OUT_W = 7;

   // Operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STS_BADPOS   = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd4;

endpackage

@@ hw/rtl/pal_ram.sv @@
module pal_ram import pal_pkg::*; #(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int WIDTH = DATA_W,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/positional_array_list_engine.sv @@
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------------------------
// req_      | in        | req_valid/req_stall  | op, position, data_value, search_key
// rsp_      | out       | rsp_valid/rsp_stall  | status, found_index, entry_value,
//           |           |                      | entry_count, last
//
// One request at a time: req_stall is high from the cycle after acceptance until the last
// result is in the output register, which may still be waiting when the next one is taken.
// Insert shifts entries up, delete shifts them down, search scans from index 0 to the first
// hit and dump streams every entry; unused op codes are taken with no result. Synchronous
// reset empties the list, returns to idle and drops a waiting result; rsp_stall holds the
// output register, pausing a dump or a result.
`include "positional_array_list_engine_macros.svh"

module positional_array_list_engine import pal_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_W-1:0]            req_op,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_data_value,
   input  logic signed [DATA_W-1:0]   req_search_key,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [FIDX_W-1:0]          rsp_found_index,
   output logic signed [DATA_W-1:0]   rsp_entry_value,
   output logic [CNT_OUT_W-1:0]       rsp_entry_count,
   output logic                       rsp_last
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WIDE_W = (POS_W > CNT_W) ? POS_W : CNT_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHUP,     // insert: move entries up, then write the new value
      ST_SHDN,     // delete: move entries down
      ST_SEARCH,
      ST_DUMP,
      ST_RESP      // single result waiting for the output register
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;        // next RAM address to read
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [DATA_W-1:0]   operand_ff, operand_in; // insert value or search key
   logic                pend_ff, pend_in;      // RAM read data valid this cycle
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_idx_ff, res_idx_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [FIDX_W-1:0]         rsp_found_index_ff, rsp_found_index_in;
   logic signed [DATA_W-1:0]  rsp_entry_value_ff, rsp_entry_value_in;
   logic [CNT_OUT_W-1:0]      rsp_entry_count_ff, rsp_entry_count_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              out_free;
   logic [WIDE_W-1:0] pos_w, cnt_w;
   logic              dump_last;

   // RAM port
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;

   pal_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pos_w     = WIDE_W'(req_position);
   assign cnt_w     = WIDE_W'(count_ff);
   assign dump_last = ((CNT_W'(pend_idx_ff) + CNT_ONE) == count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      operand_in    = operand_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;

      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_found_index_in = rsp_found_index_ff;
      rsp_entry_value_in = rsp_entry_value_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      rsp_last_in        = rsp_last_ff;

      wr_en   = 1'b0;
      wr_addr = pend_idx_ff;
      wr_data = rd_data;
      rd_addr = ptr_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               operand_in    = (req_op == OP_SEARCH) ? req_search_key : req_data_value;
               pos_in        = CNT_W'(req_position);
               pend_in       = 1'b0;
               res_idx_in    = '0;
               res_status_in = STS_OK;
               case (req_op)
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_RESP;
                  end
                  OP_INSERT: begin
                     if (pos_w > cnt_w) begin
                        res_status_in = STS_BADPOS;
                        state_in      = ST_RESP;
                     end else if (count_ff == CAP_CNT) begin
                        res_status_in = STS_FULL;
                        state_in      = ST_RESP;
                     end else begin
                        ptr_in   = count_ff;
                        state_in = ST_SHUP;
                     end
                  end
                  OP_DELETE: begin
                     if (pos_w >= cnt_w) begin
                        res_status_in = STS_BADPOS;
                        state_in      = ST_RESP;
                     end else begin
                        ptr_in   = CNT_W'(req_position) + CNT_ONE;
                        state_in = ST_SHDN;
                     end
                  end
                  OP_SEARCH: begin
                     ptr_in   = '0;
                     state_in = ST_SEARCH;
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        res_status_in = STS_EMPTY;
                        state_in      = ST_RESP;
                     end else begin
                        ptr_in   = '0;
                        state_in = ST_DUMP;
                     end
                  end
                  default: begin
                     // undefined op: taken and dropped
                  end
               endcase
            end
         end

         ST_SHUP: begin
            // read i-1 now, write it to i in the next cycle
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff;
               wr_data = rd_data;
            end
            if (ptr_ff > pos_ff) begin
               rd_addr     = IDX_W'(ptr_ff - CNT_ONE);
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in      = ptr_ff - CNT_ONE;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = pos_ff[IDX_W-1:0];
                  wr_data  = operand_ff;
                  count_in = count_ff + CNT_ONE;
                  state_in = ST_RESP;
               end
            end
         end

         ST_SHDN: begin
            // read i+1 now, write it to i in the next cycle
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff;
               wr_data = rd_data;
            end
            if (ptr_ff < count_ff) begin
               rd_addr     = ptr_ff[IDX_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = IDX_W'(ptr_ff - CNT_ONE);
               ptr_in      = ptr_ff + CNT_ONE;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - CNT_ONE;
                  state_in = ST_RESP;
               end
            end
         end

         ST_SEARCH: begin
            if (pend_ff && (rd_data == operand_ff)) begin
               pend_in    = 1'b0;
               res_idx_in = pend_idx_ff;
               state_in   = ST_RESP;
            end else if (ptr_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in      = ptr_ff + CNT_ONE;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  res_status_in = STS_NOTFOUND;
                  state_in      = ST_RESP;
               end
            end
         end

         ST_DUMP: begin
            if (pend_ff) begin
               // hold the read address so the data stays while stalled
               rd_addr = pend_idx_ff;
               if (out_free) begin
                  rsp_valid_in       = 1'b1;
                  rsp_status_in      = STS_OK;
                  rsp_found_index_in = FIDX_W'(pend_idx_ff);
                  rsp_entry_value_in = rd_data;
                  rsp_entry_count_in = CNT_OUT_W'(count_ff);
                  rsp_last_in        = dump_last;
                  pend_in            = 1'b0;
                  if (dump_last) begin
                     state_in = ST_IDLE;
                  end else if (ptr_ff < count_ff) begin
                     rd_addr     = ptr_ff[IDX_W-1:0];
                     pend_in     = 1'b1;
                     pend_idx_in = ptr_ff[IDX_W-1:0];
                     ptr_in      = ptr_ff + CNT_ONE;
                  end
               end
            end else if (ptr_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in      = ptr_ff + CNT_ONE;
            end
         end

         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = res_status_ff;
               rsp_found_index_in = FIDX_W'(res_idx_ff);
               rsp_entry_value_in = '0;
               rsp_entry_count_in = CNT_OUT_W'(count_ff);
               rsp_last_in        = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff             <= ptr_in;
      pos_ff             <= pos_in;
      operand_ff         <= operand_in;
      pend_idx_ff        <= pend_idx_in;
      res_status_ff      <= res_status_in;
      res_idx_ff         <= res_idx_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_found_index_ff <= rsp_found_index_in;
      rsp_entry_value_ff <= rsp_entry_value_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_index_ff;
   assign rsp_entry_value = rsp_entry_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_last        = rsp_last_ff;

   // list never grows past its capacity
   `PAL_ASSERT_IMP(a_count_cap, clock, reset, 1'b1, count_ff <= CAP_CNT)
   // shifts and the new value only land inside the occupied region or the slot just past its end
   `PAL_ASSERT_IMP(a_write_in_list, clock, reset, wr_en, CNT_W'(wr_addr) <= count_ff)
   // a result that is not the last one only comes out of a running dump
   `PAL_ASSERT_IMP(a_mid_dump, clock, reset, rsp_valid && !rsp_last, state_ff == ST_DUMP)
   // a dump of a non-empty list starts streaming
   `PAL_ASSERT_NXT(a_dump_start, clock, reset,
      accept && (req_op == OP_DUMP) && (count_ff != '0), state_ff == ST_DUMP)

endmodule

@@ verif/positional_array_list_engine_check.sv @@
module positional_array_list_engine_check import pal_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [OP_W-1:0]            req_op,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_data_value,
   input  logic signed [DATA_W-1:0]   req_search_key,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [STATUS_W-1:0]        rsp_status,
   input  logic [FIDX_W-1:0]          rsp_found_index,
   input  logic signed [DATA_W-1:0]   rsp_entry_value,
   input  logic [CNT_OUT_W-1:0]       rsp_entry_count,
   input  logic                       rsp_last,
   output int                         results_owed,
   output int                         mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [FIDX_W-1:0]         index;
      logic signed [DATA_W-1:0]  value;
      logic [CNT_OUT_W-1:0]      count;
      logic                      last;
   } list_result_type;

   list_result_type           owed_q[$];
   logic signed [DATA_W-1:0]  cells [CAPACITY];
   int                        fill;
   int                        mismatches = 0;

   function automatic void owe_result(logic [STATUS_W-1:0] status, int index,
                                      logic signed [DATA_W-1:0] value, bit last);
      list_result_type r;
      r.status = status;
      r.index  = index[FIDX_W-1:0];
      r.value  = value;
      r.count  = fill[CNT_OUT_W-1:0];
      r.last   = last;
      owed_q.push_back(r);
   endfunction

   // list behaviour for one accepted request
   function automatic void apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] position,
                                         logic signed [DATA_W-1:0] value,
                                         logic signed [DATA_W-1:0] key);
      int  p;
      int  i;
      bit  hit;
      p   = int'(position);
      hit = 1'b0;
      case (op)
         OP_CLEAR: begin
            fill = 0;
            owe_result(STS_OK, 0, '0, 1'b1);
         end
         OP_INSERT: begin
            if (p > fill) begin
               owe_result(STS_BADPOS, 0, '0, 1'b1);
            end else if (fill >= CAPACITY) begin
               owe_result(STS_FULL, 0, '0, 1'b1);
            end else begin
               for (i = fill; i > p; i--) cells[i] = cells[i-1];
               cells[p] = value;
               fill++;
               owe_result(STS_OK, 0, '0, 1'b1);
            end
         end
         OP_DELETE: begin
            if (p >= fill) begin
               owe_result(STS_BADPOS, 0, '0, 1'b1);
            end else begin
               for (i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
               fill--;
               owe_result(STS_OK, 0, '0, 1'b1);
            end
         end
         OP_SEARCH: begin
            for (i = 0; i < fill && !hit; i++) begin
               if (cells[i] == key) begin
                  owe_result(STS_OK, i, '0, 1'b1);
                  hit = 1'b1;
               end
            end
            if (!hit) owe_result(STS_NOTFOUND, 0, '0, 1'b1);
         end
         OP_DUMP: begin
            if (fill == 0) begin
               owe_result(STS_EMPTY, 0, '0, 1'b1);
            end else begin
               for (i = 0; i < fill; i++) owe_result(STS_OK, i, cells[i], i == fill - 1);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("%0t ns: list check: %s: got %0h, want %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      list_result_type want;
      if (reset) begin
         fill = 0;
         owed_q.delete();
      end else begin
         // retire first: a result can never belong to a request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (owed_q.size() == 0) begin
               report_mismatch("result with nothing owed, status", 64'(rsp_status), '0);
            end else begin
               want = owed_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_found_index !== want.index)
                  report_mismatch("found_index", 64'(rsp_found_index), 64'(want.index));
               if (rsp_entry_value !== want.value)
                  report_mismatch("entry_value", 64'(rsp_entry_value), 64'(want.value));
               if (rsp_entry_count !== want.count)
                  report_mismatch("entry_count", 64'(rsp_entry_count), 64'(want.count));
               if (rsp_last !== want.last)
                  report_mismatch("last", 64'(rsp_last), 64'(want.last));
            end
         end
         if (req_valid && !req_stall)
            apply_request(req_op, req_position, req_data_value, req_search_key);
      end
      results_owed   <= owed_q.size();
      mismatch_count <= mismatches;
   end

endmodule

@@ verif/positional_array_list_engine_tb.sv @@
module positional_array_list_engine_tb import pal_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH     = CAPACITY_DEF;
   localparam int RESET_CYCLES   = 7;
   // longest quiet stretch in a correct run is a scan of a nearly full list (an insert at
   // the head or a search miss) plus a stall burst and a request gap
   localparam int WATCHDOG_LIMIT = 1000;
   // after the last result: covers the slowest request so stray results show up
   localparam int DRAIN_CYCLES   = 100;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [OP_W-1:0]           req_op;
   logic [POS_W-1:0]          req_position;
   logic signed [DATA_W-1:0]  req_data_value;
   logic signed [DATA_W-1:0]  req_search_key;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [STATUS_W-1:0]       rsp_status;
   logic [FIDX_W-1:0]         rsp_found_index;
   logic signed [DATA_W-1:0]  rsp_entry_value;
   logic [CNT_OUT_W-1:0]      rsp_entry_count;
   logic                      rsp_last;

   int results_owed;
   int mismatch_count;

   // idling levels per phase, in percent; both zero for the closing phase
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;

   // stimulus-side copy of the list, only used to pick legal positions and hit keys
   logic signed [DATA_W-1:0] mirror_q[$];

   always #6 clock = ~clock;

   positional_array_list_engine #(.CAPACITY(LIST_DEPTH)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_data_value  (req_data_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

   positional_array_list_engine_check #(.CAPACITY(LIST_DEPTH)) u_list_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_data_value  (req_data_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last),
      .results_owed    (results_owed),
      .mismatch_count  (mismatch_count)
   );

   // Values: half fully random, a quarter from a tiny pool so duplicates are
   // common (first-match search), a quarter at the signed extremes, zero or all ones.
   function automatic logic signed [DATA_W-1:0] pick_value();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 3))
         0, 1: v = $urandom;
         2:    v = $signed($urandom_range(0, 6)) - 3;
         default: begin
            case ($urandom_range(0, 3))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7fff_ffff;
               2:       v = '0;
               default: v = '1;
            endcase
         end
      endcase
      return v;
   endfunction

   // mostly a key that is stored, otherwise anything
   function automatic logic signed [DATA_W-1:0] pick_key();
      if (mirror_q.size() > 0 && $urandom_range(0, 3) != 0)
         return mirror_q[$urandom_range(0, mirror_q.size() - 1)];
      return pick_value();
   endfunction

   // Present one request and hold it until taken. Valid stays high into the next
   // request unless a gap is drawn, so it is never dropped and raised in one step.
   task automatic issue(logic [OP_W-1:0] op, int pos, logic signed [DATA_W-1:0] value,
                        logic signed [DATA_W-1:0] key);
      int size;
      req_op         <= op;
      req_position   <= pos[POS_W-1:0];
      req_data_value <= value;
      req_search_key <= key;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      size = mirror_q.size();
      case (op)
         OP_CLEAR:  mirror_q.delete();
         OP_INSERT: if (pos <= size && size < LIST_DEPTH) mirror_q.insert(pos, value);
         OP_DELETE: if (pos < size) mirror_q.delete(pos);
         default: ;
      endcase
      if (req_gap_pct > 0 && $urandom_range(1, 100) <= req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Mixed traffic on whatever the list holds: mostly legal requests with
   // random content, the rest bad positions, unused opcodes and raw noise.
   task automatic mixed_run(int n);
      int size;
      int roll;
      repeat (n) begin
         size = mirror_q.size();
         roll = $urandom_range(1, 100);
         if (roll <= 35)
            issue(OP_INSERT, $urandom_range(0, size), pick_value(), $urandom);
         else if (roll <= 50)
            issue(OP_DELETE, (size > 0) ? $urandom_range(0, size - 1) : 0, $urandom, $urandom);
         else if (roll <= 68)
            issue(OP_SEARCH, $urandom_range(0, 127), $urandom, pick_key());
         else if (roll <= 73)
            issue(OP_DUMP, $urandom_range(0, 127), $urandom, $urandom);
         else if (roll <= 75)
            issue(OP_CLEAR, $urandom_range(0, 127), $urandom, $urandom);
         else if (roll <= 82)
            issue(OP_INSERT, $urandom_range(size + 1, 127), pick_value(), $urandom);
         else if (roll <= 88)
            issue(OP_DELETE, $urandom_range(size, 127), $urandom, $urandom);
         else if (roll <= 93)
            issue(3'($urandom_range(5, 7)), $urandom_range(0, 127), $urandom, $urandom);
         else
            issue(3'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom, $urandom);
      end
   endtask

   // Fill to capacity at random positions, poke the full list, dump it whole,
   // then drain it again by random deletes.
   task automatic full_run();
      issue(OP_CLEAR, 0, $urandom, $urandom);
      while (mirror_q.size() < LIST_DEPTH) begin
         issue(OP_INSERT, $urandom_range(0, mirror_q.size()), pick_value(), $urandom);
         if ($urandom_range(0, 9) == 0)
            issue(OP_SEARCH, 0, $urandom, pick_key());
      end
      issue(OP_INSERT, $urandom_range(0, LIST_DEPTH), pick_value(), $urandom);
      issue(OP_INSERT, LIST_DEPTH, pick_value(), $urandom);
      // bad position wins over full
      issue(OP_INSERT, $urandom_range(LIST_DEPTH + 1, 127), pick_value(), $urandom);
      issue(OP_DELETE, LIST_DEPTH, $urandom, $urandom);
      issue(OP_SEARCH, 0, $urandom, mirror_q[LIST_DEPTH - 1]);
      issue(OP_SEARCH, 0, $urandom, $urandom);
      issue(OP_DUMP, 0, $urandom, $urandom);
      while (mirror_q.size() > 0) begin
         issue(OP_DELETE, $urandom_range(0, mirror_q.size() - 1), $urandom, $urandom);
         if ($urandom_range(0, 9) == 0)
            issue(OP_SEARCH, 0, $urandom, pick_key());
      end
      issue(OP_DUMP, 0, $urandom, $urandom);
   endtask

   // Receiver: stall bursts at the current level. One assignment per step,
   // so a burst ends before the next one may start.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall_pct > 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: cycles with no handshake on either channel.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= OP_CLEAR;
      req_position   <= '0;
      req_data_value <= '0;
      req_search_key <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list corner cases, extremes, every op, unused opcodes
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      issue(OP_DUMP,   0,   '0, '0);                 // empty list dump
      issue(OP_SEARCH, 0,   '0, 32'sh7fff_ffff);     // search on empty list
      issue(OP_DELETE, 0,   '0, '0);                 // delete with nothing stored
      issue(OP_INSERT, 1,   32'sh1, '0);             // insert beyond the end
      issue(OP_INSERT, 0,   32'sh8000_0000, '0);
      issue(OP_INSERT, 1,   32'sh7fff_ffff, '0);
      issue(OP_INSERT, 0,   '0, '0);
      issue(OP_INSERT, 3,   '1, '0);                 // append at position == count
      issue(OP_INSERT, 127, '1, '0);                 // all position bits set
      issue(OP_SEARCH, 0,   '0, 32'sh7fff_ffff);
      issue(OP_SEARCH, 0,   '0, 32'sh8000_0000);
      issue(OP_SEARCH, 0,   '0, 32'sh0001_2345);     // miss
      issue(OP_DUMP,   0,   '0, '0);
      issue(OP_DELETE, 3,   '0, '0);                 // tail entry
      issue(OP_DELETE, 3,   '0, '0);                 // position == count
      issue(OP_DELETE, 127, '0, '0);
      issue(OP_INSERT, 2,   32'sh7fff_ffff, '0);     // duplicate key
      issue(OP_SEARCH, 0,   '0, 32'sh7fff_ffff);     // first of two matches
      issue(OP_DELETE, 0,   '0, '0);
      issue(3'd5,      5,   $urandom, $urandom);     // unused opcodes
      issue(3'd6,      64,  $urandom, $urandom);
      issue(3'd7,      127, '1, '1);
      issue(OP_DUMP,   0,   '0, '0);
      issue(OP_CLEAR,  127, '1, '1);
      issue(OP_DUMP,   0,   '0, '0);

      // random: a full fill with heavy idling, a calm stretch, mixed traffic with heavy idling, another full fill
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      full_run();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      mixed_run(60);
      req_gap_pct   = 50;
      rsp_stall_pct = 50;
      mixed_run(60);
      req_gap_pct   = 15;
      rsp_stall_pct = 40;
      full_run();

      // closing part without any idling
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      mixed_run(60);
      req_valid <= 1'b0;

      // the owed count is registered, so it lags the last acceptance
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
